FILE: rtl/epwd_pkg.sv
package epwd_pkg;

  // Item opcodes on the input channel.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_LOST  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_SEARCHING = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_TIMEOUT   = 3'd2;
  localparam logic [2:0] ST_LOST      = 3'd3;
  localparam logic [2:0] ST_IDLE      = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PATTERN_LEN   = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LOW   = 2'd1;
  localparam logic [1:0] CFG_PATTERN_HIGH  = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

  // Field widths and fixed values.
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned PAT_BYTES  = 16;
  localparam logic [7:0]  QUOTE_CHAR = 8'h22;
  localparam logic [15:0] TIMEOUT_RST = 16'd15;

  // Per-cell control handed from the top level to each window cell.
  typedef struct packed {
    logic shift_en;
    logic in_use;
  } cell_ctl_t;

endpackage

FILE: rtl/epwd_ifs.sv
interface epwd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_in;

  modport source (output valid, output opcode, output char_in, input ready);
  modport sink (input valid, input opcode, input char_in, output ready);
endinterface

interface epwd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

FILE: rtl/epwd_cell.sv
module epwd_cell
  import epwd_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CHAR_W-1:0] char_prev,
  input  logic [7:0]        pat_byte,
  output logic [CHAR_W-1:0] char_out,
  output logic              hit
);

  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] char_nxt;

  // Take the neighbor's character when the window shifts.
  always_comb begin
    char_nxt = ctl.shift_en ? char_prev : char_r;
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  // Compare the character this cell holds after the shift; a pattern byte
  // above the 7-bit range can never equal it.
  assign hit      = !ctl.in_use || ({1'b0, char_prev} == pat_byte);
  assign char_out = char_r;

endmodule

FILE: rtl/expect_pattern_with_deadline_core.sv
// Channel   Direction  Payload                          Accepted when
// in_ch     sink       opcode[1:0], char_in[7:0]         valid && ready
// out_ch    source     status[2:0]                      valid && ready
// cfg_*     write      cfg_index[1:0], cfg_data[63:0]   cfg_we high
//
// Each item's result is registered at the edge that accepts it and shows on
// out_ch in the next cycle. The window compare of
// all cells and the AND over their hits set the path from input to result.
// A new item is taken while the result register is empty or being drained,
// so a stalled output holds the input back. Reset is synchronous; no
// clearing pass is needed since the fill count gates the window.
module expect_pattern_with_deadline_core
  import epwd_pkg::*;
#(
  parameter int unsigned MAX_MATCH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  epwd_in_if.sink       in_ch,
  epwd_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  localparam int unsigned FILL_W = $clog2(MAX_MATCH + 1);

  // Configuration registers.
  logic [4:0]  pat_len_r;
  logic [63:0] pat_low_r;
  logic [63:0] pat_high_r;
  logic [15:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r  <= '0;
      pat_low_r  <= '0;
      pat_high_r <= '0;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LEN:   pat_len_r  <= cfg_data[4:0];
        CFG_PATTERN_LOW:   pat_low_r  <= cfg_data;
        CFG_PATTERN_HIGH:  pat_high_r <= cfg_data;
        CFG_TIMEOUT_TICKS: timeout_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pattern bytes, character 0 first.
  logic [7:0] pat_bytes [PAT_BYTES];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pat_bytes[b]     = pat_low_r[8*b +: 8];
      pat_bytes[b + 8] = pat_high_r[8*b +: 8];
    end
  end

  // Search state.
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [15:0]       elapsed_r, elapsed_nxt;
  logic              active_r, active_nxt;
  logic              out_valid_r;
  logic [2:0]        status_r, status_nxt;
  logic              accept;

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign accept        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;

  // Chain of window cells, newest character in cell 0.
  logic [CHAR_W-1:0]    hist [MAX_MATCH];
  logic [MAX_MATCH-1:0] hits;
  logic                 shift_en;

  assign shift_en = accept && active_r && (in_ch.opcode == OP_CHAR);

  for (genvar i = 0; i < MAX_MATCH; i++) begin : g_cell
    cell_ctl_t         ctl;
    logic [4:0]        pos;
    logic [CHAR_W-1:0] prev;

    // Cell i lines up with pattern character pat_len - 1 - i.
    assign pos          = pat_len_r - 5'(i) - 5'd1;
    assign ctl.shift_en = shift_en;
    assign ctl.in_use   = 5'(i) < pat_len_r;

    if (i == 0) begin : g_head
      assign prev = in_ch.char_in[CHAR_W-1:0];
    end else begin : g_body
      assign prev = hist[i-1];
    end

    epwd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .char_prev(prev),
      .pat_byte (pat_bytes[pos[3:0]]),
      .char_out (hist[i]),
      .hit      (hits[i])
    );
  end

  // Empty pattern: no characters, or a pair of double quotes.
  logic pat_empty;
  logic window_match;
  logic [FILL_W-1:0] fill_inc;
  logic [15:0] elapsed_inc;

  assign pat_empty = (pat_len_r == 5'd0) ||
                     (pat_len_r == 5'd2 && pat_bytes[0] == QUOTE_CHAR &&
                      pat_bytes[1] == QUOTE_CHAR);

  assign fill_inc    = (fill_r < FILL_W'(MAX_MATCH)) ? fill_r + 1'b1 : fill_r;
  assign elapsed_inc = (elapsed_r == 16'hffff) ? elapsed_r : elapsed_r + 16'd1;

  assign window_match = (pat_len_r <= 5'(MAX_MATCH)) &&
                        (5'(fill_inc) >= pat_len_r) && (&hits);

  // Next search state and result for the item being accepted.
  always_comb begin
    fill_nxt    = fill_r;
    elapsed_nxt = elapsed_r;
    active_nxt  = active_r;
    status_nxt  = ST_IDLE;
    if (in_ch.opcode == OP_START) begin
      fill_nxt    = '0;
      elapsed_nxt = '0;
      active_nxt  = !pat_empty;
      status_nxt  = pat_empty ? ST_FOUND : ST_SEARCHING;
    end else if (!active_r) begin
      status_nxt = ST_IDLE;
    end else begin
      case (in_ch.opcode)
        OP_CHAR: begin
          fill_nxt   = fill_inc;
          active_nxt = !window_match;
          status_nxt = window_match ? ST_FOUND : ST_SEARCHING;
        end
        OP_TICK: begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= timeout_r) begin
            active_nxt = 1'b0;
            status_nxt = ST_TIMEOUT;
          end else begin
            status_nxt = ST_SEARCHING;
          end
        end
        default: begin
          active_nxt = 1'b0;
          status_nxt = ST_LOST;
        end
      endcase
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      elapsed_r   <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      fill_r      <= fill_nxt;
      elapsed_r   <= elapsed_nxt;
      active_r    <= active_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

endmodule
